@@ hdl/button_click_classifier_assert.svh @@
// ---------------------------------------------------------------------------
// Button click classifier assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define BCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bcc_pkg.sv @@
// ---------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the button click classifier and its checker.
// ---------------------------------------------------------------------------
package bcc_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int TALLY_W     = 8;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_SHORT        = 3'd1,
    EV_DOUBLE       = 3'd2,
    EV_LONG         = 3'd3,
    EV_REPEAT       = 3'd4,
    EV_SHORT_REPEAT = 3'd5
  } event_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LONG_PRESS    = 2'd0,
    CFG_REPEAT_IVL    = 2'd1,
    CFG_DOUBLE_WINDOW = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST    = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_IVL_RST    = 16'd200;
  localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd250;

endpackage

@@ hdl/button_click_classifier.sv @@
// A result passes from its input transfer through the input register, then
// the result register; one item per cycle is sustained while out_tready
// does not stall. The single classify step between the two registers
// updates the click state in the same cycle it forms the result.
// Reset (rst_n, synchronous): both stages empty, click state cleared,
// timing registers back to 500 / 200 / 250 ms.
// ---------------------------------------------------------------------------
// button_click_classifier
// Classifies sampled button levels into click, double click, long press and
// hold repeat events.
// ---------------------------------------------------------------------------
module button_click_classifier
  import bcc_pkg::*;
#(
  parameter int TIME_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [0] button_pressed, [TIME_WIDTH:1] now_ms, zero pad above
  input  logic [((TIME_WIDTH+8)/8)*8-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] event_code, [3] press_edge, [4] level_now, zero pad above
  output logic [OUT_TDATA_W-1:0]        out_tdata,
  input  logic                          cfg_wen,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_W-1:0]              cfg_wdata
);

  localparam int TW = TIME_WIDTH;

  logic [CFG_W-1:0]   long_press_r, repeat_ivl_r, dbl_window_r;

  logic               s1_valid_r;
  logic               s1_level_r;
  logic [TW-1:0]      s1_now_r;

  logic               prev_level_r, prev_level_nxt;
  logic [TW-1:0]      press_stamp_r, press_stamp_nxt;
  logic [TW-1:0]      release_stamp_r, release_stamp_nxt;
  logic [TW-1:0]      repeat_stamp_r, repeat_stamp_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               pending_r, pending_nxt;
  logic               long_fired_r, long_fired_nxt;

  logic               out_valid_r;
  event_t             ev_r, ev_nxt;
  logic               edge_r, edge_nxt;
  logic               level_r;

  logic               advance;
  logic               rise, fall;
  logic [TW-1:0]      press_el, repeat_el, release_el;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RST;
      repeat_ivl_r <= REPEAT_IVL_RST;
      dbl_window_r <= DOUBLE_WINDOW_RST;
    end else if (cfg_wen) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_LONG_PRESS:    long_press_r <= cfg_wdata;
        CFG_REPEAT_IVL:    repeat_ivl_r <= cfg_wdata;
        CFG_DOUBLE_WINDOW: dbl_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_level_r <= in_tdata[0];
      s1_now_r   <= in_tdata[TW:1];
    end
  end

  // classify
  always_comb begin
    rise = s1_level_r && !prev_level_r;
    fall = !s1_level_r && prev_level_r;

    prev_level_nxt    = s1_level_r;
    press_stamp_nxt   = rise ? s1_now_r : press_stamp_r;
    repeat_stamp_nxt  = rise ? s1_now_r : repeat_stamp_r;
    long_fired_nxt    = rise ? 1'b0 : long_fired_r;
    release_stamp_nxt = fall ? s1_now_r : release_stamp_r;
    tally_nxt         = tally_r;
    pending_nxt       = pending_r;
    if (fall) begin
      if (!long_fired_r) begin
        tally_nxt   = tally_r + TALLY_W'(1);
        pending_nxt = 1'b1;
      end else begin
        tally_nxt   = '0;
        pending_nxt = 1'b0;
      end
    end

    press_el   = s1_now_r - press_stamp_nxt;
    repeat_el  = s1_now_r - repeat_stamp_nxt;
    release_el = s1_now_r - release_stamp_nxt;

    ev_nxt   = EV_NONE;
    edge_nxt = rise;

    if (s1_level_r && (press_el > TW'(long_press_r))) begin
      if (!long_fired_nxt) begin
        ev_nxt           = EV_LONG;
        long_fired_nxt   = 1'b1;
        repeat_stamp_nxt = s1_now_r;
      end else if (repeat_el > TW'(repeat_ivl_r)) begin
        ev_nxt           = (tally_nxt == TALLY_W'(1)) ? EV_SHORT_REPEAT : EV_REPEAT;
        repeat_stamp_nxt = s1_now_r;
      end
    end

    if (!s1_level_r && pending_nxt && (release_el > TW'(dbl_window_r))) begin
      if (tally_nxt == TALLY_W'(1)) begin
        ev_nxt = EV_SHORT;
      end else if (tally_nxt >= TALLY_W'(2)) begin
        ev_nxt = EV_DOUBLE;
      end
      pending_nxt = 1'b0;
      tally_nxt   = '0;
    end
  end

  // click state, updated as each item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r    <= 1'b0;
      press_stamp_r   <= '0;
      release_stamp_r <= '0;
      repeat_stamp_r  <= '0;
      tally_r         <= '0;
      pending_r       <= 1'b0;
      long_fired_r    <= 1'b0;
    end else if (s1_valid_r && advance) begin
      prev_level_r    <= prev_level_nxt;
      press_stamp_r   <= press_stamp_nxt;
      release_stamp_r <= release_stamp_nxt;
      repeat_stamp_r  <= repeat_stamp_nxt;
      tally_r         <= tally_nxt;
      pending_r       <= pending_nxt;
      long_fired_r    <= long_fired_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      ev_r    <= ev_nxt;
      edge_r  <= edge_nxt;
      level_r <= s1_level_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, level_r, edge_r, ev_r};

endmodule

@@ hdl/bcc_checker.sv @@
// ---------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the button click classifier result stream.
// ---------------------------------------------------------------------------
`include "button_click_classifier_assert.svh"

module bcc_checker
  import bcc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       ev_hold, ev_click;
  logic [2:0] ev;

  assign ev       = out_tdata[2:0];
  assign ev_hold  = (ev == EV_LONG) || (ev == EV_REPEAT) || (ev == EV_SHORT_REPEAT);
  assign ev_click = (ev == EV_SHORT) || (ev == EV_DOUBLE);

  `BCC_ASSERT_NEXT(a_out_held, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `BCC_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  `BCC_ASSERT_NOW(a_edge_level, out_tvalid && out_tdata[3], out_tdata[4], "edge while released")
  `BCC_ASSERT_NOW(a_hold_level, out_tvalid && ev_hold, out_tdata[4], "hold event while released")
  `BCC_ASSERT_NOW(a_click_level, out_tvalid && ev_click, !out_tdata[4], "click while pressed")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
